>>> design/thr_pwm_pkg.sv
// shared types and constants for the throttle axis to pulse-width block
`default_nettype none

package thr_pwm_pkg;

    localparam int DATA_W   = 12;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int DIV_STEPS = 12;

    localparam logic [DATA_W-1:0] RAMP_STEP       = 12'd15;
    localparam logic [DATA_W-1:0] SNAP_BAND       = 12'd10;
    localparam logic [DATA_W-1:0] NEAR_CENTRE     = 12'd1;
    localparam logic [DATA_W-1:0] FALLBACK_LOW    = 12'd0;
    localparam logic [DATA_W-1:0] FALLBACK_CENTRE = 12'd2048;
    localparam logic [DATA_W-1:0] FALLBACK_HIGH   = 12'd4095;

    localparam logic [DATA_W-1:0] RST_CAL_LOW       = 12'd0;
    localparam logic [DATA_W-1:0] RST_CAL_CENTRE    = 12'd2048;
    localparam logic [DATA_W-1:0] RST_CAL_HIGH      = 12'd4095;
    localparam logic [DATA_W-1:0] RST_DEAD_ZONE     = 12'd0;
    localparam logic [DATA_W-1:0] RST_PULSE_LOW     = 12'd1000;
    localparam logic [DATA_W-1:0] RST_PULSE_NEUTRAL = 12'd1500;
    localparam logic [DATA_W-1:0] RST_PULSE_HIGH    = 12'd2000;

    typedef enum logic [2:0] {
        REG_CAL_LOW       = 3'd0,
        REG_CAL_CENTRE    = 3'd1,
        REG_CAL_HIGH      = 3'd2,
        REG_DEAD_ZONE     = 3'd3,
        REG_PULSE_LOW     = 3'd4,
        REG_PULSE_NEUTRAL = 3'd5,
        REG_PULSE_HIGH    = 3'd6,
        REG_MIRROR        = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_SUM,
        S_SNAP,
        S_RAMP
    } state_t;

endpackage

`default_nettype wire

>>> design/thr_pwm_in_if.sv
// sample channel: valid, ready, one raw throttle item and a restart flag
`default_nettype none

interface thr_pwm_in_if;
    logic                            valid;
    logic                            ready;
    logic [thr_pwm_pkg::DATA_W-1:0]  sample;
    logic                            restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

>>> design/thr_pwm_out_if.sv
// pulse channel: valid, ready and one pulse width item
`default_nettype none

interface thr_pwm_out_if;
    logic                            valid;
    logic                            ready;
    logic [thr_pwm_pkg::DATA_W-1:0]  pulse_width;

    modport source (output valid, output pulse_width, input ready);
    modport sink   (input valid, input pulse_width, output ready);
endinterface

`default_nettype wire

>>> design/throttle_axis_to_pwm_ramp.sv
// Throttle axis map: one raw 12-bit sample in, one slew-limited pulse width out.
// Each accepted item runs through a small sequencer: deadzone and clamp, segment
// setup, one 12x12 multiply, 12 steps of a restoring divider, then sum and
// mirror, endpoint/neutral snap and the fall ramp. The result is offered once the
// ramp state loads the output register, and the next item is taken only after the
// block returns to idle, so a new sample is not taken before the last one is done.
// The sample channel is not ready while an item is in work. The result sits in
// its own output register, so a stalled result only holds the block at its final
// ramp step. Registers sit on an APB port at byte address 4*index; write them
// only while the block is idle.
`default_nettype none

module throttle_axis_to_pwm_ramp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [thr_pwm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [thr_pwm_pkg::APB_DW-1:0]   pwdata,
    output logic      [thr_pwm_pkg::APB_DW-1:0]   prdata,
    output logic                                  pready,
    thr_pwm_in_if.sink                            sample_ch,
    thr_pwm_out_if.source                         pulse_ch
);
    import thr_pwm_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    // configuration
    logic [DATA_W-1:0] cal_low_reg, cal_centre_reg, cal_high_reg, dead_zone_reg;
    logic [DATA_W-1:0] pulse_low_reg, pulse_neutral_reg, pulse_high_reg;
    logic              mirror_reg;

    // sequencer and datapath
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] sample_reg;
    logic [DATA_W-1:0] raw_reg, mn_reg, ctr_reg, mx_reg;
    logic              near_reg;
    logic [DATA_W-1:0] num_reg, den_reg, dmag_reg, base_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] rem_reg, quo_reg;
    logic [DATA_W-1:0] v_reg, snap_reg;
    logic [DATA_W-1:0] held_reg;
    logic [DATA_W-1:0] pulse_width_reg;
    logic              out_valid_reg;

    logic              wr_en;
    reg_idx_t          wr_idx;
    logic              in_take, out_load, out_take;

    assign wr_en  = psel & penable & pwrite & pready;
    assign wr_idx = reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        case (wr_idx)
            REG_CAL_LOW:       prdata[DATA_W-1:0] = cal_low_reg;
            REG_CAL_CENTRE:    prdata[DATA_W-1:0] = cal_centre_reg;
            REG_CAL_HIGH:      prdata[DATA_W-1:0] = cal_high_reg;
            REG_DEAD_ZONE:     prdata[DATA_W-1:0] = dead_zone_reg;
            REG_PULSE_LOW:     prdata[DATA_W-1:0] = pulse_low_reg;
            REG_PULSE_NEUTRAL: prdata[DATA_W-1:0] = pulse_neutral_reg;
            REG_PULSE_HIGH:    prdata[DATA_W-1:0] = pulse_high_reg;
            REG_MIRROR:        prdata[0] = mirror_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_low_reg       <= RST_CAL_LOW;
            cal_centre_reg    <= RST_CAL_CENTRE;
            cal_high_reg      <= RST_CAL_HIGH;
            dead_zone_reg     <= RST_DEAD_ZONE;
            pulse_low_reg     <= RST_PULSE_LOW;
            pulse_neutral_reg <= RST_PULSE_NEUTRAL;
            pulse_high_reg    <= RST_PULSE_HIGH;
            mirror_reg        <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_CAL_LOW:       cal_low_reg       <= pwdata[DATA_W-1:0];
                REG_CAL_CENTRE:    cal_centre_reg    <= pwdata[DATA_W-1:0];
                REG_CAL_HIGH:      cal_high_reg      <= pwdata[DATA_W-1:0];
                REG_DEAD_ZONE:     dead_zone_reg     <= pwdata[DATA_W-1:0];
                REG_PULSE_LOW:     pulse_low_reg     <= pwdata[DATA_W-1:0];
                REG_PULSE_NEUTRAL: pulse_neutral_reg <= pwdata[DATA_W-1:0];
                REG_PULSE_HIGH:    pulse_high_reg    <= pwdata[DATA_W-1:0];
                REG_MIRROR:        mirror_reg        <= pwdata[0];
                default:           mirror_reg        <= mirror_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (sample_ch.valid) state_next = S_CLAMP;
            S_CLAMP: state_next = S_SETUP;
            S_SETUP: state_next = S_MUL;
            S_MUL:   state_next = S_DIV;
            S_DIV:   if (cnt_reg == '0) state_next = S_SUM;
            S_SUM:   state_next = S_SNAP;
            S_SNAP:  state_next = S_RAMP;
            S_RAMP:  if (!out_valid_reg || pulse_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        sample_ch.ready = 1'b0;
        out_load        = 1'b0;
        case (state_reg)
            S_IDLE:  sample_ch.ready = 1'b1;
            S_RAMP:  out_load = !out_valid_reg || pulse_ch.ready;
            default:
            begin
                sample_ch.ready = 1'b0;
                out_load        = 1'b0;
            end
        endcase
    end

    assign in_take              = sample_ch.valid & sample_ch.ready;
    assign out_take             = out_valid_reg & pulse_ch.ready;
    assign pulse_ch.valid       = out_valid_reg;
    assign pulse_ch.pulse_width = pulse_width_reg;

    // deadzone and calibration clamp
    logic [DATA_W-1:0] dz_diff, dz_raw, mn_c, ctr_c, mx_c, raw_c;
    logic              cal_ok;

    always_comb
    begin
        dz_diff = (sample_reg >= cal_centre_reg) ? sample_reg - cal_centre_reg
                                                 : cal_centre_reg - sample_reg;
        dz_raw  = (dz_diff < dead_zone_reg) ? cal_centre_reg : sample_reg;
        cal_ok  = (cal_low_reg < cal_centre_reg) && (cal_centre_reg < cal_high_reg);
        mn_c    = cal_ok ? cal_low_reg    : FALLBACK_LOW;
        ctr_c   = cal_ok ? cal_centre_reg : FALLBACK_CENTRE;
        mx_c    = cal_ok ? cal_high_reg   : FALLBACK_HIGH;
        if (dz_raw < mn_c)
            raw_c = mn_c;
        else if (dz_raw > mx_c)
            raw_c = mx_c;
        else
            raw_c = dz_raw;
    end

    // segment choice
    logic              upper_c;
    logic [DATA_W-1:0] cdiff_c, out_hi_c, out_lo_c;

    always_comb
    begin
        upper_c  = raw_reg >= ctr_reg;
        cdiff_c  = upper_c ? raw_reg - ctr_reg : ctr_reg - raw_reg;
        out_hi_c = upper_c ? pulse_high_reg    : pulse_neutral_reg;
        out_lo_c = upper_c ? pulse_neutral_reg : pulse_low_reg;
    end

    // multiply, one divider step
    logic [2*DATA_W-1:0] prod_c;
    logic [DATA_W:0]     trial_c;

    assign prod_c  = num_reg * dmag_reg;
    assign trial_c = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, den_reg};

    // sum, mirror, pulse clamp
    logic [15:0]       q16_c, sum_c, mir_c;
    logic [DATA_W-1:0] v_c;

    always_comb
    begin
        q16_c = {4'b0, quo_reg};
        if (near_reg)
            sum_c = {4'b0, pulse_neutral_reg};
        else if (neg_reg)
            sum_c = {4'b0, base_reg} - q16_c;
        else
            sum_c = {4'b0, base_reg} + q16_c;
        mir_c = mirror_reg ? ({4'b0, pulse_low_reg} + {4'b0, pulse_high_reg} - sum_c)
                           : sum_c;
        if (mir_c < {4'b0, pulse_low_reg})
            v_c = pulse_low_reg;
        else if (mir_c > {4'b0, pulse_high_reg})
            v_c = pulse_high_reg;
        else
            v_c = mir_c[DATA_W-1:0];
    end

    // snap to low end, high end, then neutral
    logic [DATA_W:0]   lo_band_c;
    logic [DATA_W+1:0] hi_band_c;
    logic [DATA_W-1:0] mdiff_c, snap_c;

    always_comb
    begin
        lo_band_c = {1'b0, pulse_low_reg} + {1'b0, SNAP_BAND};
        hi_band_c = {2'b0, pulse_high_reg} - {2'b0, SNAP_BAND};
        mdiff_c   = (v_reg >= pulse_neutral_reg) ? v_reg - pulse_neutral_reg
                                                 : pulse_neutral_reg - v_reg;
        if ({1'b0, v_reg} <= lo_band_c)
            snap_c = pulse_low_reg;
        else if ($signed({2'b0, v_reg}) >= $signed(hi_band_c))
            snap_c = pulse_high_reg;
        else if (mdiff_c <= SNAP_BAND)
            snap_c = pulse_neutral_reg;
        else
            snap_c = v_reg;
    end

    // fall ramp; zero held value means not yet initialised
    logic [DATA_W-1:0] h0_c, held_c;

    always_comb
    begin
        h0_c = (held_reg == '0) ? snap_reg : held_reg;
        if (snap_reg >= h0_c || snap_reg <= pulse_neutral_reg)
            held_c = snap_reg;
        else if (h0_c - snap_reg > RAMP_STEP)
            held_c = h0_c - RAMP_STEP;
        else
            held_c = snap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_take && sample_ch.restart)
                held_reg <= '0;
            else if (out_load)
                held_reg <= held_c;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
            if (state_reg == S_MUL)
                cnt_reg <= CNT_W'(DIV_STEPS - 1);
            else if (state_reg == S_DIV)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            sample_reg <= sample_ch.sample;
        if (out_load)
            pulse_width_reg <= held_c;
        case (state_reg)
            S_CLAMP:
            begin
                raw_reg <= raw_c;
                mn_reg  <= mn_c;
                ctr_reg <= ctr_c;
                mx_reg  <= mx_c;
            end
            S_SETUP:
            begin
                near_reg <= cdiff_c <= NEAR_CENTRE;
                num_reg  <= upper_c ? raw_reg - ctr_reg : raw_reg - mn_reg;
                den_reg  <= upper_c ? mx_reg - ctr_reg  : ctr_reg - mn_reg;
                base_reg <= out_lo_c;
                neg_reg  <= out_hi_c < out_lo_c;
                dmag_reg <= (out_hi_c >= out_lo_c) ? out_hi_c - out_lo_c
                                                   : out_lo_c - out_hi_c;
            end
            S_MUL:
            begin
                // quotient fits 12 bits, so the high half is already below the divisor
                rem_reg <= prod_c[2*DATA_W-1:DATA_W];
                quo_reg <= prod_c[DATA_W-1:0];
            end
            S_DIV:
            begin
                if (!trial_c[DATA_W])
                    rem_reg <= trial_c[DATA_W-1:0];
                else
                    rem_reg <= {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_reg <= {quo_reg[DATA_W-2:0], ~trial_c[DATA_W]};
            end
            S_SUM:   v_reg    <= v_c;
            S_SNAP:  snap_reg <= snap_c;
            default: v_reg    <= v_reg;
        endcase
    end

endmodule

`default_nettype wire
